[hw/rtl/block_request_validator_defines.svh]
// assertion macros shared by the request validator rtl
// depends on nothing; taken in by files that carry checks
`ifndef BLOCK_REQUEST_VALIDATOR_DEFINES_SVH
`define BLOCK_REQUEST_VALIDATOR_DEFINES_SVH

// same-cycle implication check
`define BRV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brv check failed");

// next-cycle implication check
`define BRV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brv check failed");

`endif

[hw/rtl/brv_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and constants of the block request validator
// depends on nothing
package brv_pkg;

   // field widths
   localparam int ID_W     = 64;
   localparam int OP_W     = 3;
   localparam int SECTOR_W = 48;
   localparam int SEC8_W   = 8;
   localparam int BSIZE_W  = 13;
   localparam int DISK_W   = 61;
   localparam int START_W  = 60;
   localparam int SIZE_W   = 16;
   localparam int CNT_W    = 7;
   localparam int SEGB_W   = 22;
   localparam int PAGEP_W  = 21;
   localparam int CSR_IDX_W = 2;

   // request limits
   localparam logic [CNT_W-1:0]   MAX_SEGMENTS = 7'd11;
   localparam logic [CNT_W-1:0]   CNT_SAT      = 7'd127;
   localparam logic [PAGEP_W-1:0] PAGE_BYTES   = 21'd4096;

   // queue depth default
   localparam int QUEUE_DEPTH_DEF = 4;

   // operation codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_READ    = 3'd0;
   localparam op_type OP_WRITE   = 3'd1;
   localparam op_type OP_FLUSH   = 3'd2;
   localparam op_type OP_DISCARD = 3'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_ONLY  = 2'd2;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [BSIZE_W-1:0] block_size;
      logic [DISK_W-1:0]  disk_size;
      logic               read_only;
   } cfg_type;

   // classified beat handed from front to back
   typedef struct packed {
      logic [ID_W-1:0]    id;
      op_type             op;
      logic [START_W-1:0] start;
      logic               start_ovf;
      logic               has_seg;
      logic               bad_order;
      logic               cross_page;
      logic [SEGB_W-1:0]  seg_bytes;
      logic               eor;
   } item_type;

   // an operation that carries segment checks
   function automatic logic op_is_rwf(op_type op);
      return (op == OP_READ) || (op == OP_WRITE) || (op == OP_FLUSH);
   endfunction

endpackage

[hw/rtl/brv_front.sv]
`timescale 1ns / 1ps
// front stage: accepts request beats and classifies each segment
// depends on brv_pkg
module brv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [brv_pkg::ID_W-1:0]      in_id,
   input  brv_pkg::op_type               in_op,
   input  logic [brv_pkg::SECTOR_W-1:0]  in_sector,
   input  logic                          in_has_seg,
   input  logic [brv_pkg::SEC8_W-1:0]    in_first,
   input  logic [brv_pkg::SEC8_W-1:0]    in_last,
   input  logic                          in_eor,
   input  logic [brv_pkg::BSIZE_W-1:0]   block_size,
   output logic                          out_valid,
   input  logic                          out_ready,
   output brv_pkg::item_type             out_item
);
   import brv_pkg::*;

   logic                 front_valid_ff, front_valid_in;
   item_type             front_item_ff, front_item_in;
   logic [DISK_W-1:0]    start_prod;
   logic [PAGEP_W-1:0]   page_prod;
   logic [SEC8_W:0]      span;

   // stage frees up when empty or when the queue takes its beat
   assign in_ready = !front_valid_ff || out_ready;

   // start byte, page reach and segment length
   assign start_prod = in_sector * block_size;
   assign page_prod  = in_last * block_size;
   assign span       = {1'b0, in_last} - {1'b0, in_first} + 9'd1;

   always_comb begin
      front_item_in.id         = in_id;
      front_item_in.op         = in_op;
      front_item_in.start      = start_prod[START_W-1:0];
      front_item_in.start_ovf  = start_prod[DISK_W-1];
      front_item_in.has_seg    = in_has_seg;
      front_item_in.bad_order  = in_first > in_last;
      front_item_in.cross_page = page_prod >= PAGE_BYTES;
      front_item_in.seg_bytes  = span * block_size;
      front_item_in.eor        = in_eor;
   end

   // stage valid
   always_comb begin
      front_valid_in = front_valid_ff;
      if (in_ready) begin
         front_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         front_item_ff <= front_item_in;
      end
   end

   assign out_valid = front_valid_ff;
   assign out_item  = front_item_ff;

endmodule

[hw/rtl/brv_queue.sv]
`timescale 1ns / 1ps
// short queue of classified beats between front and back
// depends on brv_pkg and the assertion macro header
`include "block_request_validator_defines.svh"
module brv_queue #(
   parameter int DEPTH = brv_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  brv_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output brv_pkg::item_type  pop_item,
   output logic               empty
);
   import brv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

   item_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   logic                push_ok, pop_ok;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];

   // back side never pops an empty queue
   `BRV_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !empty)
   // a lone push grows the fill count by one
   `BRV_ASSERT_NEXT(a_count_step, clock, reset, push_ok && !pop_ok, count_ff == $past(count_ff) + 1'b1)

endmodule

[hw/rtl/brv_back.sv]
`timescale 1ns / 1ps
// back end: request state, segment accounting and result staging
// depends on brv_pkg and the assertion macro header
`include "block_request_validator_defines.svh"
module brv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  brv_pkg::item_type            item,
   output logic                         item_pop,
   input  brv_pkg::cfg_type             cfg,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [brv_pkg::ID_W-1:0]     rsp_echo_id,
   output brv_pkg::op_type              rsp_echo_operation,
   output logic                         rsp_status,
   output logic [brv_pkg::START_W-1:0]  rsp_start_byte,
   output logic [brv_pkg::SIZE_W-1:0]   rsp_size_bytes
);
   import brv_pkg::*;

   // finished request waiting for the final bounds check
   typedef struct packed {
      logic [ID_W-1:0]    id;
      op_type             op;
      logic               no_seg;
      logic               err;
      logic [START_W-1:0] start;
      logic [SIZE_W-1:0]  size;
   } done_type;

   // request state
   logic                 in_request_ff, in_request_in;
   logic [CNT_W-1:0]     seg_count_ff, seg_count_in;
   logic [SIZE_W-1:0]    size_total_ff, size_total_in;
   logic                 error_seen_ff, error_seen_in;
   logic [START_W-1:0]   start_held_ff, start_held_in;
   op_type               op_held_ff, op_held_in;
   logic [ID_W-1:0]      id_held_ff, id_held_in;

   logic                 done_valid_ff, done_valid_in;
   done_type             done_ff, done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_echo_id_ff;
   op_type               rsp_echo_operation_ff;
   logic                 rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]   rsp_start_byte_ff, rsp_start_byte_in;
   logic [SIZE_W-1:0]    rsp_size_bytes_ff, rsp_size_bytes_in;

   logic                 out_load, done_load;
   logic [SIZE_W+6:0]    size_sum;
   logic [DISK_W-1:0]    end_byte;
   logic                 beyond_disk;

   // stall chain: output register, done register, queue
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign done_load = !done_valid_ff || out_load;
   assign item_pop  = item_valid && done_load;

   // per-beat request state update
   always_comb begin
      id_held_in    = id_held_ff;
      op_held_in    = op_held_ff;
      start_held_in = start_held_ff;
      error_seen_in = error_seen_ff;
      seg_count_in  = seg_count_ff;
      size_total_in = size_total_ff;
      in_request_in = in_request_ff;
      size_sum      = '0;
      if (item_pop) begin
         // first beat latches tag, operation, start byte and overflow flag, and clears the counts
         if (!in_request_ff) begin
            id_held_in    = item.id;
            op_held_in    = item.op;
            start_held_in = item.start;
            error_seen_in = item.start_ovf;
            seg_count_in  = '0;
            size_total_in = '0;
         end
         // segment checks and saturating byte total
         size_sum = {7'd0, size_total_in} + {1'b0, item.seg_bytes};
         if (item.has_seg && op_is_rwf(op_held_in)) begin
            if (seg_count_in >= MAX_SEGMENTS) begin
               error_seen_in = 1'b1;
            end else if (item.bad_order) begin
               error_seen_in = 1'b1;
            end else if (item.cross_page) begin
               error_seen_in = 1'b1;
            end else if (!error_seen_in) begin
               size_total_in = (|size_sum[SIZE_W+6:SIZE_W]) ? '1 : size_sum[SIZE_W-1:0];
            end
         end
         if (item.has_seg && (seg_count_in != CNT_SAT)) begin
            seg_count_in = seg_count_in + 1'b1;
         end
         in_request_in = !item.eor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_request_ff <= 1'b0;
         seg_count_ff  <= '0;
         size_total_ff <= '0;
         error_seen_ff <= 1'b0;
         start_held_ff <= '0;
         op_held_ff    <= OP_READ;
         id_held_ff    <= '0;
      end else begin
         in_request_ff <= in_request_in;
         seg_count_ff  <= seg_count_in;
         size_total_ff <= size_total_in;
         error_seen_ff <= error_seen_in;
         start_held_ff <= start_held_in;
         op_held_ff    <= op_held_in;
         id_held_ff    <= id_held_in;
      end
   end

   // done record from the closing beat
   always_comb begin
      done_in.id     = id_held_in;
      done_in.op     = op_held_in;
      done_in.no_seg = (seg_count_in == '0);
      done_in.err    = error_seen_in;
      done_in.start  = start_held_in;
      done_in.size   = size_total_in;
      done_valid_in  = done_valid_ff;
      if (done_load) begin
         done_valid_in = item_pop && item.eor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_valid_ff <= 1'b0;
      end else begin
         done_valid_ff <= done_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_load && item_pop && item.eor) begin
         done_ff <= done_in;
      end
   end

   // disk bounds and final status
   assign end_byte    = {1'b0, done_ff.start} + {45'd0, done_ff.size};
   assign beyond_disk = end_byte > cfg.disk_size;

   always_comb begin
      rsp_status_in     = 1'b0;
      rsp_start_byte_in = '0;
      rsp_size_bytes_in = '0;
      if ((done_ff.op == OP_DISCARD) || ((done_ff.op == OP_FLUSH) && done_ff.no_seg)) begin
         rsp_status_in = 1'b0;
      end else if (!op_is_rwf(done_ff.op)) begin
         rsp_status_in = 1'b1;
      end else if (cfg.read_only && (done_ff.op != OP_READ)) begin
         rsp_status_in = 1'b1;
      end else if (done_ff.err || beyond_disk) begin
         rsp_status_in = 1'b1;
      end else begin
         rsp_start_byte_in = done_ff.start;
         rsp_size_bytes_in = done_ff.size;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = done_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (out_load && done_valid_ff) begin
         rsp_echo_id_ff        <= done_ff.id;
         rsp_echo_operation_ff <= done_ff.op;
         rsp_status_ff         <= rsp_status_in;
         rsp_start_byte_ff     <= rsp_start_byte_in;
         rsp_size_bytes_ff     <= rsp_size_bytes_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echo_id        = rsp_echo_id_ff;
   assign rsp_echo_operation = rsp_echo_operation_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_start_byte     = rsp_start_byte_ff;
   assign rsp_size_bytes     = rsp_size_bytes_ff;

   // a failed request carries no byte range
   `BRV_ASSERT_NOW(a_err_zero_range, clock, reset, rsp_valid_ff && rsp_status_ff, (rsp_start_byte_ff == '0) && (rsp_size_bytes_ff == '0))
   // the closing beat ends the open request
   `BRV_ASSERT_NEXT(a_eor_closes, clock, reset, item_pop && item.eor, !in_request_ff && done_valid_ff)

endmodule

[hw/rtl/block_request_validator.sv]
`timescale 1ns / 1ps
// top level of the block request validator: config registers, front, queue, back
// depends on brv_pkg, brv_front, brv_queue and brv_back
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_ready | one beat per segment or segmentless item
//  rsp_    | out       | rsp_valid/rsp_ready | one beat per request, on its last item
//  csr_    | in        | csr_we              | register index and write data
//
// one beat accepted per cycle unless the queue is full; the multiplies sit in the front register stage
// after the front register takes the last beat, the result passes through queue, done and output registers
// the queue lets the front keep taking beats while the result side is stalled, until the queue fills
// synchronous reset sets control and config state only; no clearing pass is needed
module block_request_validator #(
   parameter int QUEUE_DEPTH = brv_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [brv_pkg::ID_W-1:0]        req_request_id,
   input  brv_pkg::op_type                 req_operation,
   input  logic [brv_pkg::SECTOR_W-1:0]    req_sector_number,
   input  logic                            req_has_segment,
   input  logic [brv_pkg::SEC8_W-1:0]      req_first_sector,
   input  logic [brv_pkg::SEC8_W-1:0]      req_final_sector,
   input  logic                            req_end_of_request,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [brv_pkg::ID_W-1:0]        rsp_echo_id,
   output brv_pkg::op_type                 rsp_echo_operation,
   output logic                            rsp_status,
   output logic [brv_pkg::START_W-1:0]     rsp_start_byte,
   output logic [brv_pkg::SIZE_W-1:0]      rsp_size_bytes,
   input  logic                            csr_we,
   input  logic [brv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brv_pkg::DISK_W-1:0]      csr_wdata
);
   import brv_pkg::*;

   logic [BSIZE_W-1:0]   block_size_ff, block_size_in;
   logic [DISK_W-1:0]    disk_size_ff, disk_size_in;
   logic                 read_only_ff, read_only_in;
   cfg_type              cfg;

   logic                 front_valid;
   item_type             front_item;
   logic                 queue_full, queue_empty;
   item_type             queue_item;
   logic                 back_pop;

   // register write decode
   always_comb begin
      block_size_in = block_size_ff;
      disk_size_in  = disk_size_ff;
      read_only_in  = read_only_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE: block_size_in = csr_wdata[BSIZE_W-1:0];
            CSR_DISK_SIZE:  disk_size_in  = csr_wdata;
            CSR_READ_ONLY:  read_only_in  = csr_wdata[0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= 13'd512;
         disk_size_ff  <= '0;
         read_only_ff  <= 1'b0;
      end else begin
         block_size_ff <= block_size_in;
         disk_size_ff  <= disk_size_in;
         read_only_ff  <= read_only_in;
      end
   end

   assign cfg.block_size = block_size_ff;
   assign cfg.disk_size  = disk_size_ff;
   assign cfg.read_only  = read_only_ff;

   // accept and classify
   brv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_id      (req_request_id),
      .in_op      (req_operation),
      .in_sector  (req_sector_number),
      .in_has_seg (req_has_segment),
      .in_first   (req_first_sector),
      .in_last    (req_final_sector),
      .in_eor     (req_end_of_request),
      .block_size (block_size_ff),
      .out_valid  (front_valid),
      .out_ready  (!queue_full),
      .out_item   (front_item)
   );

   // decoupling queue
   brv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   // request accounting and result
   brv_back u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (!queue_empty),
      .item               (queue_item),
      .item_pop           (back_pop),
      .cfg                (cfg),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_echo_id        (rsp_echo_id),
      .rsp_echo_operation (rsp_echo_operation),
      .rsp_status         (rsp_status),
      .rsp_start_byte     (rsp_start_byte),
      .rsp_size_bytes     (rsp_size_bytes)
   );

endmodule
